FILE: hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and helper functions for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BLOCK_W  = 512;
   localparam int unsigned ROUNDS   = 64;
   localparam int unsigned LEN_W    = 64;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam logic [5:0]  LEN_POS  = 6'd56;   // first byte of the length field
   localparam logic [5:0]  LAST_POS = 6'd63;
   localparam logic [5:0]  LAST_RND = 6'd63;
   localparam logic [5:0]  LAST_LEN = 6'd7;
   localparam logic [1:0]  LAST_IDX = 2'd3;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic [1:0]  part_index;
      logic        last_part;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   localparam logic [WORD_W-1:0] INIT_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] ROUND_K [0:ROUNDS-1] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: hw/rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one round per cycle, digest out in four parts.
// ----------------------------------------------------------------------------
// A request carrying only a byte is taken at once while idle. Every 64th
// byte starts the compression: 64 rounds on the single shared round unit,
// then the hash update, with req_stall high throughout. A request with
// end_of_message starts padding, which shifts one pad or length byte into
// the block per cycle, with a turnaround step before the length field (and
// a second compression when the tail leaves fewer than 9 free bytes),
// followed by the final compression. The digest then leaves as four 64-bit
// responses, most significant first, one per cycle while rsp_stall is low;
// no new request is taken until the last one goes. The sustained rate is
// set by the round unit, as no byte is taken during a compression.
module sha256_byte_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);

   localparam int unsigned W = sha_pkg::WORD_W;

   sha_pkg::state_type state_ff, state_in;

   logic [sha_pkg::BLOCK_W-1:0] blk_ff, blk_in;    // byte buffer / schedule window
   logic [5:0]                  fill_ff, fill_in;
   logic [sha_pkg::LEN_W-1:0]   bits_ff, bits_in;
   logic [5:0]                  rnd_ff, rnd_in;
   logic                        pad_ff, pad_in;    // message closed, padding
   logic                        mark_ff, mark_in;  // 0x80 already shifted in
   logic                        final_ff, final_in;
   logic [W-1:0]                hash_ff [8];
   logic [W-1:0]                hash_in [8];
   logic [W-1:0]                v_ff [8];
   logic [W-1:0]                v_in [8];

   logic [W-1:0] w_cur, w_new, t1, t2;
   logic [1:0]   part;

   // round unit
   always_comb begin
      w_cur = blk_ff[511:480];
      w_new = sha_pkg::small_sigma1(blk_ff[63:32]) + blk_ff[223:192]
            + sha_pkg::small_sigma0(blk_ff[479:448]) + w_cur;
      t1 = v_ff[7] + sha_pkg::big_sigma1(v_ff[4])
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha_pkg::ROUND_K[rnd_ff] + w_cur;
      t2 = sha_pkg::big_sigma0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign part = rnd_ff[1:0];

   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      rnd_in   = rnd_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      final_in = final_ff;
      hash_in  = hash_ff;
      v_in     = v_ff;

      req_stall = (state_ff != sha_pkg::ST_IDLE);
      rsp_valid = (state_ff == sha_pkg::ST_OUT);
      rsp_data.digest_part = {hash_ff[{part, 1'b0}], hash_ff[{part, 1'b1}]};
      rsp_data.part_index  = part;
      rsp_data.last_part   = (part == sha_pkg::LAST_IDX);

      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.end_of_message) begin
                  pad_in  = 1'b1;
                  mark_in = 1'b0;
               end
               if (req_data.has_byte) begin
                  blk_in  = {blk_ff[503:0], req_data.data_byte};
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
               end
               if (req_data.has_byte && fill_ff == sha_pkg::LAST_POS) begin
                  state_in = sha_pkg::ST_ROUND;
                  rnd_in   = '0;
                  v_in     = hash_ff;
               end else if (req_data.end_of_message) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            blk_in  = {blk_ff[479:0], w_new};
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == sha_pkg::LAST_RND) begin
               state_in = sha_pkg::ST_ADD;
            end
         end
         sha_pkg::ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            rnd_in = '0;
            if (final_ff) begin
               state_in = sha_pkg::ST_OUT;
            end else if (pad_ff) begin
               state_in = sha_pkg::ST_PAD;
            end else begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         sha_pkg::ST_PAD: begin
            if (mark_ff && fill_ff == sha_pkg::LEN_POS) begin
               state_in = sha_pkg::ST_LEN;
               rnd_in   = '0;
            end else begin
               blk_in  = {blk_ff[503:0], (mark_ff ? 8'h00 : sha_pkg::PAD_MARK)};
               mark_in = 1'b1;
               fill_in = fill_ff + 6'd1;
               if (fill_ff == sha_pkg::LAST_POS) begin
                  state_in = sha_pkg::ST_ROUND;
                  rnd_in   = '0;
                  v_in     = hash_ff;
               end
            end
         end
         sha_pkg::ST_LEN: begin
            // bit count leaves big-endian; the counter restarts afterwards
            blk_in  = {blk_ff[503:0], bits_ff[63:56]};
            bits_in = {bits_ff[55:0], 8'h00};
            fill_in = fill_ff + 6'd1;
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == sha_pkg::LAST_LEN) begin
               state_in = sha_pkg::ST_ROUND;
               final_in = 1'b1;
               rnd_in   = '0;
               v_in     = hash_ff;
            end
         end
         sha_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               rnd_in = rnd_ff + 6'd1;
               if (part == sha_pkg::LAST_IDX) begin
                  state_in = sha_pkg::ST_IDLE;
                  hash_in  = sha_pkg::INIT_HASH;
                  bits_in  = '0;
                  pad_in   = 1'b0;
                  mark_in  = 1'b0;
                  final_in = 1'b0;
                  rnd_in   = '0;
               end
            end
         end
         default: begin
            state_in = sha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         rnd_ff   <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         final_ff <= 1'b0;
         hash_ff  <= sha_pkg::INIT_HASH;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         rnd_ff   <= rnd_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         final_ff <= final_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      v_ff   <= v_in;
   end

   // compression always starts on an empty buffer position
   a_round_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha_pkg::ST_ROUND) |-> (fill_ff == '0))
      else $error("fill count not zero during compression");

   // the digest is only shown once the final block is done
   a_out_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha_pkg::ST_OUT) |-> (final_ff && pad_ff && fill_ff == '0))
      else $error("digest shown before final block");

   a_len_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha_pkg::ST_LEN) |-> (rnd_ff <= sha_pkg::LAST_LEN
                                         && fill_ff >= sha_pkg::LEN_POS))
      else $error("length field out of place");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_part) |=>
         (state_ff == sha_pkg::ST_IDLE && bits_ff == '0 && !pad_ff
          && hash_ff[0] == sha_pkg::INIT_HASH[0]))
      else $error("no restart after last digest part");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while digest pending");

endmodule

FILE: bench/sha256_byte_stream_hasher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_test
// Self-checking bench: streams byte messages into the hasher, computes each
// SHA-256 digest in a bench-side model and compares the four digest parts.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_test;

   localparam int CYCLE_LIMIT = 200000;

   localparam logic [31:0] K_TABLE [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] H_START [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sha_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sha_pkg::rsp_type rsp_data;

   // digest model state
   logic [31:0]      hash_h [0:7];
   logic [7:0]       msg_block [0:63];
   int               fill_bytes;
   logic [63:0]      bits_done;
   sha_pkg::rsp_type digest_parts_q [$];

   int               mismatch_count = 0;
   int               requests_sent  = 0;
   int               cycle_count    = 0;
   int               burst_left     = 0;
   bit               gaps_on        = 1'b0;
   bit               hold_on        = 1'b0;
   logic [15:0]      stall_pattern  = '0;
   logic [3:0]       stall_phase    = '0;
   sha_pkg::rsp_type part_want;

   sha256_byte_stream_hasher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: repeating stall pattern plus a long hold when asked
   always @(negedge clock) begin
      stall_phase <= stall_phase + 4'd1;
      rsp_stall   <= hold_on | stall_pattern[stall_phase];
   end

   // ------------------------------------------------------------------------
   // digest model
   // ------------------------------------------------------------------------
   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_digest();
      int i;
      for (i = 0; i < 8; i++) hash_h[i] = H_START[i];
      fill_bytes = 0;
      bits_done  = '0;
   endfunction

   function automatic void compress_msg_block();
      logic [31:0] w [0:63];
      logic [31:0] v [0:7];
      logic [31:0] t1, t2, s0, s1;
      int i;
      for (i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (i = 0; i < 8; i++) v[i] = hash_h[i];
      for (i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) hash_h[i] += v[i];
   endfunction

   // apply one accepted request; on end of message queue the four parts
   function automatic void absorb_request(input sha_pkg::req_type r);
      logic [63:0]      total_bits;
      sha_pkg::rsp_type part;
      int               k;
      if (r.has_byte) begin
         msg_block[fill_bytes] = r.data_byte;
         fill_bytes++;
         if (fill_bytes == 64) begin
            compress_msg_block();
            bits_done  += 64'd512;
            fill_bytes = 0;
         end
      end
      if (r.end_of_message) begin
         total_bits = bits_done + 64'(fill_bytes) * 64'd8;
         msg_block[fill_bytes] = PAD_BYTE;
         fill_bytes++;
         // no room left for the length field: pad out and take a second block
         if (fill_bytes > 56) begin
            while (fill_bytes < 64) begin
               msg_block[fill_bytes] = 8'h00;
               fill_bytes++;
            end
            compress_msg_block();
            fill_bytes = 0;
         end
         while (fill_bytes < 56) begin
            msg_block[fill_bytes] = 8'h00;
            fill_bytes++;
         end
         for (k = 0; k < 8; k++) msg_block[56+k] = total_bits[63-8*k -: 8];
         compress_msg_block();
         for (k = 0; k < 4; k++) begin
            part.digest_part = {hash_h[2*k], hash_h[2*k+1]};
            part.part_index  = 2'(k);
            part.last_part   = (k == 3);
            digest_parts_q   = {digest_parts_q, part};
         end
         restart_digest();
      end
   endfunction

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_parts_q.size() == 0) begin
            report_mismatch("unexpected digest part", rsp_data.digest_part, '0);
         end else begin
            part_want = digest_parts_q.pop_front();
            if (rsp_data.digest_part !== part_want.digest_part)
               report_mismatch("digest_part", rsp_data.digest_part, part_want.digest_part);
            if (rsp_data.part_index !== part_want.part_index)
               report_mismatch("part_index", 64'(rsp_data.part_index),
                               64'(part_want.part_index));
            if (rsp_data.last_part !== part_want.last_part)
               report_mismatch("last_part", 64'(rsp_data.last_part),
                               64'(part_want.last_part));
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   function automatic sha_pkg::req_type make_request(input logic has_byte,
                                                     input logic [7:0] data_byte,
                                                     input logic end_of_message);
      sha_pkg::req_type r;
      r.has_byte       = has_byte;
      r.data_byte      = data_byte;
      r.end_of_message = end_of_message;
      return r;
   endfunction

   function automatic logic [15:0] pick_stall_pattern();
      logic [15:0] p;
      case ($urandom_range(0, 3))
         0: p = '0;
         1: p = 16'($urandom);
         2: p = 16'($urandom) & 16'($urandom);
         default: p = 16'($urandom) | 16'($urandom);
      endcase
      // always leave at least one open slot per period
      p &= ~(16'h1 << $urandom_range(0, 15));
      return p;
   endfunction

   task automatic send_request(input sha_pkg::req_type r);
      if (burst_left == 0) begin
         if (gaps_on) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_request(r);
      if (r.has_byte || r.end_of_message) requests_sent++;
   endtask

   // random content; noise_pct sprinkles idle requests between bytes
   task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_request(make_request(1'b0, 8'($urandom), 1'b0));
         send_request(make_request(1'b1, 8'($urandom), end_on_byte && i == len - 1));
      end
      if (!end_on_byte || len == 0)
         send_request(make_request(1'b0, 8'($urandom), 1'b1));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_empty_message();
      gaps_on       = 1'b0;
      stall_pattern = '0;
      send_request(make_request(1'b0, 8'h00, 1'b1));
      // byte field must be ignored without has_byte
      send_request(make_request(1'b0, 8'hff, 1'b1));
   endtask

   task automatic test_short_messages();
      gaps_on       = 1'b1;
      stall_pattern = pick_stall_pattern();
      send_request(make_request(1'b1, 8'h61, 1'b0));
      send_request(make_request(1'b1, 8'h62, 1'b0));
      send_request(make_request(1'b1, 8'h63, 1'b1));
      send_request(make_request(1'b1, 8'h00, 1'b0));
      send_request(make_request(1'b0, 8'h00, 1'b1));
      send_request(make_request(1'b1, 8'hff, 1'b1));
   endtask

   task automatic test_idle_requests();
      gaps_on       = 1'b0;
      stall_pattern = 16'haaaa;
      send_request(make_request(1'b0, 8'hff, 1'b0));
      send_request(make_request(1'b0, 8'h00, 1'b0));
      send_request(make_request(1'b1, PAD_BYTE, 1'b0));
      send_request(make_request(1'b0, 8'h55, 1'b0));
      send_request(make_request(1'b0, 8'haa, 1'b1));
   endtask

   // output held off long enough that the pending digest stalls the input
   task automatic test_backpressure();
      gaps_on       = 1'b0;
      stall_pattern = '0;
      fork
         begin
            hold_on = 1'b1;
            repeat (300) @(posedge clock);
            hold_on = 1'b0;
         end
      join_none
      send_message(3, 1'b1, 0);
      send_message(8, 1'b0, 0);
   endtask

   task automatic test_random_messages();
      int first_sent;
      int msgs;
      int pick;
      int len;
      first_sent = requests_sent;
      msgs       = 0;
      while (requests_sent - first_sent < 125 || msgs < 8) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            len = $urandom_range(120, 135);
         else if (pick < 55)
            len = $urandom_range(0, 8);
         else if (pick < 80)
            len = $urandom_range(55, 65);   // one or two final blocks
         else
            len = $urandom_range(9, 54);
         gaps_on       = ($urandom_range(0, 3) != 0);
         stall_pattern = pick_stall_pattern();
         send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 10 : 0);
         msgs++;
      end
   endtask

   initial begin
      restart_digest();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_message();
      test_short_messages();
      test_idle_requests();
      test_backpressure();
      test_random_messages();

      @(negedge clock);
      req_valid <= 1'b0;
      while (digest_parts_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
